@@ rtl/mbet_pkg.sv @@
// Shared types, constants and helpers of the escape-time engine.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package mbet_pkg;

    localparam int FRAC_BITS    = 28;
    localparam int MAX_DIM      = 4096;
    localparam int MAX_ITER_CAP = 1023;

    localparam int WORD_W  = 32;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int PIX_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int STEP_W  = 29;
    localparam int ITER_W  = 10;
    localparam int OFS_W   = PIX_W + 2;
    localparam int CIDX_W  = 8;

    // escape bound 4.0 in the scale of a full product
    localparam logic [PROD_W-1:0] ESC_THRESHOLD = PROD_W'(4) << (2 * FRAC_BITS);

    localparam logic signed [PROD_W-1:0] WORD_MAX_W = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] WORD_MIN_W = -PROD_W'(64'sd2147483648);

    // register indexes of the configuration port
    localparam logic [CIDX_W-1:0] REG_CENTER_REAL = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_CENTER_IMAG = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] REG_STEP_REAL   = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_STEP_IMAG   = CIDX_W'(3);
    localparam logic [CIDX_W-1:0] REG_IMG_WIDTH   = CIDX_W'(4);
    localparam logic [CIDX_W-1:0] REG_IMG_HEIGHT  = CIDX_W'(5);
    localparam logic [CIDX_W-1:0] REG_ITER_LIMIT  = CIDX_W'(6);

    typedef struct packed {
        logic signed [WORD_W-1:0] center_real;
        logic signed [WORD_W-1:0] center_imag;
        logic [STEP_W-1:0]        step_real;
        logic [STEP_W-1:0]        step_imag;
        logic [SIZE_W-1:0]        image_width;
        logic [SIZE_W-1:0]        image_height;
        logic [ITER_W-1:0]        iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic              inside_res;
        logic [PIX_W-1:0]  out_x;
        logic [PIX_W-1:0]  out_y;
    } t_result;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        if (v > WORD_MAX_W) begin
            return WORD_MAX_W[WORD_W-1:0];
        end
        if (v < WORD_MIN_W) begin
            return WORD_MIN_W[WORD_W-1:0];
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/mandelbrot_escape_time.sv @@
// Top level of the Mandelbrot escape-time engine: channels and result register.
// Depends on mbet_pkg, mbet_cfg, mbet_core (which holds mbet_mult).
//
// Usage:
//   Slave stream: one transaction carries a pixel; tdata holds pixel_x in
//   bits 11:0 and pixel_y in bits 23:12. The pixel maps to c = center +
//   (2*pixel - size) * step / 2 in signed Q4.28; z then runs z*z + c from
//   z = c until |z|^2 > 4 or the iteration limit is hit.
//   Master stream: one transaction per pixel; tdata holds iterations (9:0),
//   out_x (21:10) and out_y (33:22); tuser bit 0 is the inside flag.
//   Config channel: a write at index 0..6 updates center_real, center_imag,
//   step_real, step_imag, image_width, image_height, iteration_limit; other
//   indexes are dropped. The channel is always ready.
//   Sequence: one shared 32x32 multiplier does all products. Mapping runs
//   through MAP_X, MAP_Y and LOAD_C; each escape test with its update runs
//   through two squares, the cross product and the update. The slave side
//   is ready only while the engine is idle, from the hand-over on.
//   Stall: a finished result sits in the output register while the next
//   pixel is accepted and worked on; a second result holds in the engine
//   until the output register frees up.
//   Reset: synchronous, active low; registers return to defaults, streams empty.
`default_nettype none

module mandelbrot_escape_time (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel_x [11:0], pixel_y [23:12]
    input  wire logic [23:0] i_s_tdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // iterations [9:0], out_x [21:10], out_y [33:22], zero [39:34]
    output logic [39:0]      o_m_tdata,
    // inside_res [0]
    output logic [0:0]       o_m_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    mbet_pkg::t_cfg    w_cfg;
    mbet_pkg::t_result w_res;
    mbet_pkg::t_result r_res;
    logic              r_m_valid;
    logic              w_core_ready;
    logic              w_core_done;
    logic              w_take;
    logic              w_start;

    assign o_cfg_ready = 1'b1;

    mbet_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign w_start = i_s_tvalid && w_core_ready;
    // hand the result over when the output register is free or draining
    assign w_take  = w_core_done && (!r_m_valid || i_m_tready);

    mbet_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_start  (w_start),
        .i_px     (i_s_tdata[11:0]),
        .i_py     (i_s_tdata[23:12]),
        .o_ready  (w_core_ready),
        .o_done   (w_core_done),
        .i_take   (w_take),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_take) begin
            r_m_valid <= 1'b1;
            r_res     <= w_res;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_s_tready = w_core_ready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_res.out_y, r_res.out_x, r_res.iterations};
    assign o_m_tuser  = r_res.inside_res;

    // engine turns busy right after taking a pixel
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("engine still ready after accepting a pixel");

    // a handed-over result shows up on the master side next cycle, with the engine ready again
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (o_m_tvalid && o_s_tready))
        else $error("handed-over result missing on the output");

    // a waiting result in the engine blocks new pixels
    a_done_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_core_done && o_s_tready))
        else $error("engine ready while holding a result");

endmodule

`default_nettype wire

@@ rtl/mbet_cfg.sv @@
// Configuration register file of the escape-time engine.
// Depends on mbet_pkg for the register indexes and the t_cfg bundle.
`default_nettype none

module mbet_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr,
    input  wire logic [mbet_pkg::CIDX_W-1:0] i_index,
    input  wire logic [31:0]                 i_data,
    output mbet_pkg::t_cfg                   o_cfg
);

    mbet_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_real     <= -32'sd201326592;
            r_cfg.center_imag     <= 32'sd0;
            r_cfg.step_real       <= mbet_pkg::STEP_W'(1258291);
            r_cfg.step_imag       <= mbet_pkg::STEP_W'(1677722);
            r_cfg.image_width     <= mbet_pkg::SIZE_W'(640);
            r_cfg.image_height    <= mbet_pkg::SIZE_W'(480);
            r_cfg.iteration_limit <= mbet_pkg::ITER_W'(100);
        end else if (i_wr) begin
            case (i_index)
                mbet_pkg::REG_CENTER_REAL: r_cfg.center_real     <= i_data;
                mbet_pkg::REG_CENTER_IMAG: r_cfg.center_imag     <= i_data;
                mbet_pkg::REG_STEP_REAL:   r_cfg.step_real       <= i_data[mbet_pkg::STEP_W-1:0];
                mbet_pkg::REG_STEP_IMAG:   r_cfg.step_imag       <= i_data[mbet_pkg::STEP_W-1:0];
                mbet_pkg::REG_IMG_WIDTH:   r_cfg.image_width     <= i_data[mbet_pkg::SIZE_W-1:0];
                mbet_pkg::REG_IMG_HEIGHT:  r_cfg.image_height    <= i_data[mbet_pkg::SIZE_W-1:0];
                mbet_pkg::REG_ITER_LIMIT:  r_cfg.iteration_limit <= i_data[mbet_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/mbet_mult.sv @@
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on mbet_pkg for the word widths.
`default_nettype none

module mbet_mult (
    input  wire logic                               i_clk,
    input  wire logic signed [mbet_pkg::WORD_W-1:0] i_a,
    input  wire logic signed [mbet_pkg::WORD_W-1:0] i_b,
    output logic signed [mbet_pkg::PROD_W-1:0]      o_prod
);

    logic signed [mbet_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/mbet_core.sv @@
// Sequencer and datapath of one pixel: maps the coordinate, then runs
// z = z*z + c through the shared multiplier. Depends on mbet_pkg, mbet_mult.
`default_nettype none

module mbet_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mbet_pkg::t_cfg             i_cfg,
    input  wire logic                       i_start,
    input  wire logic [mbet_pkg::PIX_W-1:0] i_px,
    input  wire logic [mbet_pkg::PIX_W-1:0] i_py,
    output logic                            o_ready,
    output logic                            o_done,
    input  wire logic                       i_take,
    output mbet_pkg::t_result               o_result
);

    localparam int F  = mbet_pkg::FRAC_BITS;
    localparam int W  = mbet_pkg::WORD_W;
    localparam int PW = mbet_pkg::PROD_W;
    localparam int IW = mbet_pkg::ITER_W;
    localparam int OW = mbet_pkg::OFS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MAP_X, S_MAP_Y, S_LOAD_C, S_SQ_RE, S_SQ_IM, S_CROSS, S_UPDATE, S_DONE
    } t_state;

    t_state                r_state;
    logic [mbet_pkg::PIX_W-1:0] r_px, r_py;
    logic signed [OW-1:0]  r_dx, r_dy;
    logic signed [W-1:0]   r_cre, r_cim, r_re, r_im;
    logic [PW-1:0]         r_r2, r_i2;
    logic [IW-1:0]         r_count, r_limit;
    logic                  r_inside;

    logic signed [W-1:0]   w_a, w_b;
    logic signed [PW-1:0]  w_prod;
    logic signed [PW-1:0]  w_off;
    logic signed [W-1:0]   w_map;
    logic signed [PW-1:0]  w_diff;
    logic signed [W-1:0]   n_re, n_im;
    logic [IW-1:0]         n_count;
    logic                  w_escape;
    logic [mbet_pkg::SIZE_W-1:0] w_szx, w_szy;
    logic [IW-1:0]         w_limit;

    mbet_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // clamp sizes and the limit to their maxima
    always_comb begin
        w_szx = (int'(i_cfg.image_width) > mbet_pkg::MAX_DIM) ?
                mbet_pkg::SIZE_W'(mbet_pkg::MAX_DIM) : i_cfg.image_width;
        w_szy = (int'(i_cfg.image_height) > mbet_pkg::MAX_DIM) ?
                mbet_pkg::SIZE_W'(mbet_pkg::MAX_DIM) : i_cfg.image_height;
        w_limit = (int'(i_cfg.iteration_limit) > mbet_pkg::MAX_ITER_CAP) ?
                  IW'(mbet_pkg::MAX_ITER_CAP) : i_cfg.iteration_limit;
    end

    // operand select for the shared multiplier
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            S_MAP_X: begin
                w_a = W'(r_dx);
                w_b = signed'(W'(i_cfg.step_real));
            end
            S_MAP_Y: begin
                w_a = W'(r_dy);
                w_b = signed'(W'(i_cfg.step_imag));
            end
            S_SQ_RE: begin
                w_a = r_re;
                w_b = r_re;
            end
            S_SQ_IM: begin
                w_a = r_im;
                w_b = r_im;
            end
            S_CROSS: begin
                w_a = r_re;
                w_b = r_im;
            end
            default: ;
        endcase
    end

    // halve toward zero, add center (real in MAP_Y, imaginary in LOAD_C)
    always_comb begin
        w_off = (w_prod + signed'(PW'({1'b0, w_prod[PW-1]}))) >>> 1;
        if (r_state == S_MAP_Y) begin
            w_map = mbet_pkg::sat_word(PW'(i_cfg.center_real) + w_off);
        end else begin
            w_map = mbet_pkg::sat_word(PW'(i_cfg.center_imag) + w_off);
        end
    end

    // escape test and update, the cross product sits in w_prod
    always_comb begin
        w_escape = (r_r2 + r_i2) > mbet_pkg::ESC_THRESHOLD;
        w_diff   = signed'(r_r2) - signed'(r_i2);
        n_re     = mbet_pkg::sat_word((w_diff >>> F) + PW'(r_cre));
        n_im     = mbet_pkg::sat_word((w_prod >>> (F - 1)) + PW'(r_cim));
        n_count  = r_count + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_px     <= i_px;
                        r_py     <= i_py;
                        r_dx     <= signed'({1'b0, i_px, 1'b0}) - signed'(OW'(w_szx));
                        r_dy     <= signed'({1'b0, i_py, 1'b0}) - signed'(OW'(w_szy));
                        r_limit  <= w_limit;
                        r_count  <= '0;
                        r_state  <= S_MAP_X;
                    end
                end
                S_MAP_X: r_state <= S_MAP_Y;
                S_MAP_Y: begin
                    r_cre   <= w_map;
                    r_state <= S_LOAD_C;
                end
                S_LOAD_C: begin
                    r_cim <= w_map;
                    r_re  <= r_cre;
                    r_im  <= w_map;
                    if (r_limit == '0) begin
                        r_inside <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SQ_RE;
                    end
                end
                S_SQ_RE: r_state <= S_SQ_IM;
                S_SQ_IM: begin
                    r_r2    <= w_prod;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_i2    <= w_prod;
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (w_escape) begin
                        r_inside <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_re    <= n_re;
                        r_im    <= n_im;
                        r_count <= n_count;
                        if (n_count == r_limit) begin
                            r_inside <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SQ_RE;
                        end
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_result.iterations = r_count;
    assign o_result.inside_res = r_inside;
    assign o_result.out_x      = r_px;
    assign o_result.out_y      = r_py;

endmodule

`default_nettype wire

@@ tb/tb_mandelbrot_escape_time.sv @@
// Testbench of the Mandelbrot escape-time engine: random and directed pixels,
// register settings at every phase, results checked against a built-in predictor.
// Depends on mbet_pkg and mandelbrot_escape_time from the rtl folder.
module tb_mandelbrot_escape_time;
    timeunit 1ns;
    timeprecision 1ps;

    // Run shape
    localparam int SETTLE_CYCLES = 8;      // quiet time before register writes
    localparam int END_CYCLES    = 32;     // quiet time before the verdict
    localparam int HOLD_CYCLES   = 2000;   // one long receiver hold-off
    localparam int STUCK_LIMIT   = 20000;  // ~5x the slowest pixel plus the hold-off
    localparam int IDLE_PCT      = 28;
    localparam int RANDOM_PHASES = 9;
    localparam int PRINT_CAP     = 40;

    // Indexes past the register file; the engine must drop writes to them
    localparam logic [mbet_pkg::CIDX_W-1:0] REG_FIRST_UNUSED = mbet_pkg::CIDX_W'(7);
    localparam logic [mbet_pkg::CIDX_W-1:0] REG_LAST_UNUSED  = mbet_pkg::CIDX_W'(255);

    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483647 - 64'sd1;

    localparam mbet_pkg::t_cfg DEFAULT_CFG = '{
        center_real:     -32'sd201326592,
        center_imag:     32'sd0,
        step_real:       29'd1258291,
        step_imag:       29'd1677722,
        image_width:     13'd640,
        image_height:    13'd480,
        iteration_limit: 10'd100
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic [23:0] s_tdata   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Pixels waiting to be sent ({pixel_y, pixel_x}) and results still owed
    logic [23:0]       pending_pixels[$];
    mbet_pkg::t_result expected_pixels[$];
    mbet_pkg::t_cfg    engine_cfg = DEFAULT_CFG;   // shadow of the register file

    int   mismatch_count = 0;
    int   stuck_cycles   = 0;
    logic no_idle        = 1'b0;   // suppress random gaps on both streams
    logic hold_go        = 1'b0;   // start the long receiver hold-off
    logic rx_hold        = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mandelbrot_escape_time u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_word(input longint v);
        if (v > WORD_HI) return WORD_HI;
        if (v < WORD_LO) return WORD_LO;
        return v;
    endfunction

    // c = center + (2*pixel - size) * step / 2, halved toward zero, then clamped.
    // Sizes above the maximum act as the maximum; a zero size is used as it is.
    function automatic longint pixel_to_plane(
        input logic [mbet_pkg::PIX_W-1:0]         pix,
        input logic [mbet_pkg::SIZE_W-1:0]        size,
        input logic [mbet_pkg::STEP_W-1:0]        step,
        input logic signed [mbet_pkg::WORD_W-1:0] center);
        longint span;
        longint delta;
        span  = (size > mbet_pkg::MAX_DIM) ? longint'(mbet_pkg::MAX_DIM) : longint'(size);
        delta = 2 * longint'(pix) - span;
        return clamp_word(longint'(center) + (delta * longint'(step)) / 2);
    endfunction

    // Escape-time count of one pixel under the given register settings
    function automatic mbet_pkg::t_result escape_time(
        input mbet_pkg::t_cfg                   cfg,
        input logic [mbet_pkg::PIX_W-1:0]       px,
        input logic [mbet_pkg::PIX_W-1:0]       py);
        longint            c_re;
        longint            c_im;
        longint            re;
        longint            im;
        longint            next_re;
        logic [63:0]       re_sq;
        logic [63:0]       im_sq;
        int                limit;
        int                count;
        mbet_pkg::t_result res;
        c_re  = pixel_to_plane(px, cfg.image_width, cfg.step_real, cfg.center_real);
        c_im  = pixel_to_plane(py, cfg.image_height, cfg.step_imag, cfg.center_imag);
        limit = (cfg.iteration_limit > mbet_pkg::MAX_ITER_CAP) ?
                mbet_pkg::MAX_ITER_CAP : int'(cfg.iteration_limit);
        re    = c_re;
        im    = c_im;
        count = 0;
        while (count < limit) begin
            re_sq = re * re;
            im_sq = im * im;
            // exact wide magnitude, strictly above 4.0 escapes
            if ({1'b0, re_sq} + {1'b0, im_sq} > {1'b0, mbet_pkg::ESC_THRESHOLD}) break;
            // arithmetic right shift of a signed value rounds toward minus infinity
            next_re = clamp_word(((longint'(re_sq) - longint'(im_sq)) >>> mbet_pkg::FRAC_BITS)
                                 + c_re);
            im      = clamp_word(((re * im) >>> (mbet_pkg::FRAC_BITS - 1)) + c_im);
            re      = next_re;
            count++;
        end
        res.iterations = count[mbet_pkg::ITER_W-1:0];
        res.inside_res = (count >= limit);
        res.out_x      = px;
        res.out_y      = py;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Register shadow: follow every accepted write, drop unknown indexes
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            engine_cfg <= DEFAULT_CFG;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mbet_pkg::REG_CENTER_REAL: begin
                    engine_cfg.center_real <= cfg_data;
                end
                mbet_pkg::REG_CENTER_IMAG: begin
                    engine_cfg.center_imag <= cfg_data;
                end
                mbet_pkg::REG_STEP_REAL: begin
                    engine_cfg.step_real <= cfg_data[mbet_pkg::STEP_W-1:0];
                end
                mbet_pkg::REG_STEP_IMAG: begin
                    engine_cfg.step_imag <= cfg_data[mbet_pkg::STEP_W-1:0];
                end
                mbet_pkg::REG_IMG_WIDTH: begin
                    engine_cfg.image_width <= cfg_data[mbet_pkg::SIZE_W-1:0];
                end
                mbet_pkg::REG_IMG_HEIGHT: begin
                    engine_cfg.image_height <= cfg_data[mbet_pkg::SIZE_W-1:0];
                end
                mbet_pkg::REG_ITER_LIMIT: begin
                    engine_cfg.iteration_limit <= cfg_data[mbet_pkg::ITER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pixel driver: offer the head of the pending queue, hold it while the
    // engine is busy, predict its result on the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                // record the expectation before dropping the pixel so the
                // drain loop never sees both queues empty mid-transaction
                expected_pixels.push_back(escape_time(engine_cfg, s_tdata[11:0],
                                                      s_tdata[23:12]));
                void'(pending_pixels.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction unchanged
            end else if (pending_pixels.size() != 0 &&
                         (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pixels[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transaction with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        mbet_pkg::t_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with no pixel outstanding, out_x",
                                    m_tdata[21:10], -1);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[9:0] != want.iterations)
                        report_mismatch($sformatf("iterations of (%0d,%0d)", want.out_x,
                                        want.out_y), m_tdata[9:0], want.iterations);
                    if (m_tuser[0] != want.inside_res)
                        report_mismatch($sformatf("inside flag of (%0d,%0d)", want.out_x,
                                        want.out_y), m_tuser[0], want.inside_res);
                    if (m_tdata[21:10] != want.out_x)
                        report_mismatch("out_x", m_tdata[21:10], want.out_x);
                    if (m_tdata[33:22] != want.out_y)
                        report_mismatch("out_y", m_tdata[33:22], want.out_y);
                end
            end
            m_tready <= !rx_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long hold-off: keep the receiver stalled so the output register and the
    // engine both fill and the slave side stops taking pixels.
    initial begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog: count edges with no transaction on any channel
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [mbet_pkg::CIDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Write the whole register file; fill unused upper bits of the narrower
    // registers with noise so the engine has to truncate those writes to the register width.
    task automatic load_setup(input logic signed [31:0] cr, input logic signed [31:0] ci,
                              input logic [mbet_pkg::STEP_W-1:0] sr,
                              input logic [mbet_pkg::STEP_W-1:0] si,
                              input logic [mbet_pkg::SIZE_W-1:0] w,
                              input logic [mbet_pkg::SIZE_W-1:0] h,
                              input logic [mbet_pkg::ITER_W-1:0] lim);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(mbet_pkg::REG_CENTER_REAL, cr);
        write_reg(mbet_pkg::REG_CENTER_IMAG, ci);
        write_reg(mbet_pkg::REG_STEP_REAL, {noise[31:mbet_pkg::STEP_W], sr});
        write_reg(mbet_pkg::REG_STEP_IMAG, {noise[mbet_pkg::STEP_W-1:26], si});
        write_reg(mbet_pkg::REG_IMG_WIDTH, {noise[31:mbet_pkg::SIZE_W], w});
        write_reg(mbet_pkg::REG_IMG_HEIGHT, {noise[18:0], h});
        write_reg(mbet_pkg::REG_ITER_LIMIT, {noise[21:0], lim});
    endtask

    task automatic queue_pixel(input int x, input int y);
        pending_pixels.push_back({y[mbet_pkg::PIX_W-1:0], x[mbet_pkg::PIX_W-1:0]});
    endtask

    // Hold back new work until every owed result is back, then let it settle
    task automatic wait_quiet();
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly land inside the image; a quarter anywhere on the 12-bit range
    function automatic int pick_coord(input int size);
        if ($urandom_range(3) == 0) return $urandom_range(4095);
        return $urandom_range(size - 1);
    endfunction

    // Random register set, biased toward views of the set itself, with deep
    // zooms, wild centers and odd sizes now and then. Keep slow phases short.
    task automatic random_setup(output int w_eff, output int h_eff, output int items);
        logic signed [31:0]                cr;
        logic signed [31:0]                ci;
        logic [mbet_pkg::STEP_W-1:0]       sr;
        logic [mbet_pkg::STEP_W-1:0]       si;
        logic [mbet_pkg::SIZE_W-1:0]       w;
        logic [mbet_pkg::SIZE_W-1:0]       h;
        logic [mbet_pkg::ITER_W-1:0]       lim;
        int                                roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            cr = $urandom;
            ci = $urandom;
        end else begin
            cr = $urandom_range(671088640) - 536870912;   // -2.0 .. 0.5
            ci = $urandom_range(671088640) - 335544320;   // -1.25 .. 1.25
        end
        sr = (roll % 7 == 0) ? mbet_pkg::STEP_W'($urandom) :
             mbet_pkg::STEP_W'($urandom_range(1, 1 << $urandom_range(22)));
        si = (roll % 9 == 0) ? mbet_pkg::STEP_W'($urandom) :
             mbet_pkg::STEP_W'($urandom_range(1, 1 << $urandom_range(22)));
        w  = ($urandom_range(9) == 0) ? mbet_pkg::SIZE_W'($urandom_range(8191)) :
             mbet_pkg::SIZE_W'($urandom_range(1, 4096));
        h  = ($urandom_range(9) == 0) ? mbet_pkg::SIZE_W'($urandom_range(8191)) :
             mbet_pkg::SIZE_W'($urandom_range(1, 4096));
        roll = $urandom_range(99);
        if (roll < 55)      lim = mbet_pkg::ITER_W'($urandom_range(1, 40));
        else if (roll < 85) lim = mbet_pkg::ITER_W'($urandom_range(41, 200));
        else if (roll < 95) lim = mbet_pkg::ITER_W'($urandom_range(201, 1023));
        else                lim = '0;
        load_setup(cr, ci, sr, si, w, h, lim);
        w_eff = (w == 0 || w > mbet_pkg::MAX_DIM) ? mbet_pkg::MAX_DIM : int'(w);
        h_eff = (h == 0 || h > mbet_pkg::MAX_DIM) ? mbet_pkg::MAX_DIM : int'(h);
        items = (lim > 200) ? 8 : 48;
    endtask

    initial begin
        int phase;
        int n;
        int w_eff;
        int h_eff;
        int items;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: image corners, the far corner that clamps the
        // mapping, the image center that stays inside for the full limit
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(320, 240);
        queue_pixel(639, 479);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        wait_quiet();

        // Zero iteration limit: no iteration, reported inside
        load_setup(DEFAULT_CFG.center_real, DEFAULT_CFG.center_imag, DEFAULT_CFG.step_real,
                   DEFAULT_CFG.step_imag, DEFAULT_CFG.image_width, DEFAULT_CFG.image_height,
                   '0);
        queue_pixel(320, 240);
        queue_pixel(5, 7);
        wait_quiet();

        // Zero steps map every pixel onto the origin; run the full 10-bit limit
        load_setup('0, '0, '0, '0, 13'd4096, 13'd1, 10'd1023);
        queue_pixel(123, 456);
        queue_pixel(4095, 4095);
        wait_quiet();

        // Center at the word extremes, unit and full steps, zero and oversize
        // image; also poke indexes past the register file
        load_setup(32'sh7FFF_FFFF, 32'sh8000_0000, 29'h1000_0000, 29'd1, '0, 13'd8191, 10'd1);
        write_reg(REG_FIRST_UNUSED, $urandom);
        write_reg(REG_LAST_UNUSED, $urandom);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(2048, 1);
        wait_quiet();

        load_setup(32'sh8000_0000, 32'sh7FFF_FFFF, 29'd1, 29'h1000_0000, 13'd4096, 13'd1, 10'd7);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(2048, 0);
        wait_quiet();

        // Random part: each phase loads fresh settings while idle, streams
        // pixels, then drains. One phase carries the long hold-off, another
        // runs with no gaps at all.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_setup(w_eff, h_eff, items);
            no_idle <= (phase == 5);
            if (phase == 2) hold_go <= 1'b1;
            for (n = 0; n < items; n++) begin
                queue_pixel(pick_coord(w_eff), pick_coord(h_eff));
            end
            wait_quiet();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("results never delivered", 0, expected_pixels.size());
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mbet_pkg.sv
rtl/mbet_cfg.sv
rtl/mbet_mult.sv
rtl/mbet_core.sv
rtl/mandelbrot_escape_time.sv
tb/tb_mandelbrot_escape_time.sv
